>>> sv/rar_pkg.sv
// Shared types, constants and helpers for the right-angle image rotator.
// No dependencies; imported by every module of the block.
package rar_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int DIM_W       = 7;
  localparam int MODE_W      = 2;
  localparam int PIX_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd4;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_90   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_180  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_270  = 2'd3;

  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

  typedef struct packed {
    logic             command;
    logic [PIX_W-1:0] pixel_in;
  } rar_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last_pixel;
    logic             ready_res;
    logic [DIM_W-1:0] new_origin_x;
    logic [DIM_W-1:0] new_origin_y;
  } rar_res_t;

  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
    logic              ready;
    logic              last;
    logic [DIM_W-1:0]  nox;
    logic [DIM_W-1:0]  noy;
  } rar_op_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                 logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] sat_sub(logic [DIM_W-1:0] a, logic [DIM_W-1:0] b);
    logic [DIM_W-1:0] r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

>>> sv/rar_front.sv
// Front end: configuration registers, load/drain counters and address mapping.
// Turns each accepted item into one store operation. Depends on rar_pkg.
module rar_front import rar_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_wdata_i,
  input  logic                 accept_i,
  input  rar_in_t              item_i,
  output rar_op_t              op_o
);

  logic [DIM_W-1:0]  width_q, height_q, origin_x_q, origin_y_q;
  logic [MODE_W-1:0] mode_q;
  logic [CNT_W-1:0]  load_count_q, load_count_d;
  logic              frame_full_q, frame_full_d;
  logic [DIM_W-1:0]  emit_outer_q, emit_outer_d, emit_inner_q, emit_inner_d;

  logic [DIM_W-1:0]   w, h, outer_lim, inner_lim, o, i, x, y, nox, noy;
  logic [CNT_W-1:0]   total, cnt_inc;
  logic [2*DIM_W-1:0] lin;
  logic               is_last, inner_end, load_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= MAX_W_DIM;
      height_q   <= MAX_H_DIM;
      mode_q     <= MODE_NONE;
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:   width_q    <= cfg_wdata_i;
        REG_IMAGE_HEIGHT:  height_q   <= cfg_wdata_i;
        REG_ROTATION_MODE: mode_q     <= cfg_wdata_i[MODE_W-1:0];
        REG_ORIGIN_X:      origin_x_q <= cfg_wdata_i;
        REG_ORIGIN_Y:      origin_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w         = clamp_dim(width_q, MAX_W_DIM);
    h         = clamp_dim(height_q, MAX_H_DIM);
    total     = CNT_W'(w) * CNT_W'(h);
    cnt_inc   = load_count_q + CNT_W'(1);
    outer_lim = mode_q[0] ? w : h;
    inner_lim = mode_q[0] ? h : w;
    o = (emit_outer_q < outer_lim) ? emit_outer_q : outer_lim - DIM_W'(1);
    i = (emit_inner_q < inner_lim) ? emit_inner_q : inner_lim - DIM_W'(1);

    case (mode_q)
      MODE_90: begin
        x = o; y = h - DIM_W'(1) - i;
        nox = sat_sub(h, origin_y_q); noy = origin_x_q;
      end
      MODE_180: begin
        y = h - DIM_W'(1) - o; x = w - DIM_W'(1) - i;
        nox = sat_sub(w, origin_x_q); noy = sat_sub(h, origin_y_q);
      end
      MODE_270: begin
        x = w - DIM_W'(1) - o; y = i;
        nox = origin_y_q; noy = sat_sub(w, origin_x_q);
      end
      default: begin
        y = o; x = i;
        nox = origin_x_q; noy = origin_y_q;
      end
    endcase

    lin       = (2*DIM_W)'(y) * (2*DIM_W)'(w) + (2*DIM_W)'(x);
    inner_end = (i + DIM_W'(1)) >= inner_lim;
    is_last   = ((o + DIM_W'(1)) >= outer_lim) && inner_end;
    load_wr   = !frame_full_q && (load_count_q < total);

    load_count_d = load_count_q;
    frame_full_d = frame_full_q;
    emit_outer_d = emit_outer_q;
    emit_inner_d = emit_inner_q;

    op_o       = '0;
    op_o.nox   = nox;
    op_o.noy   = noy;
    op_o.pixel = item_i.pixel_in;

    if (accept_i) begin
      if (item_i.command == CMD_LOAD) begin
        if (!frame_full_q) begin
          if (load_wr) begin
            load_count_d = cnt_inc;
          end
          if (load_count_d >= total) begin
            frame_full_d = 1'b1;
          end
        end
        op_o.wr   = load_wr;
        op_o.addr = load_count_q[ADDR_W-1:0];
      end else begin
        op_o.rd    = 1'b1;
        op_o.ready = frame_full_q;
        if (frame_full_q) begin
          op_o.addr = lin[ADDR_W-1:0];
          op_o.last = is_last;
          if (is_last) begin
            frame_full_d = 1'b0;
            load_count_d = '0;
            emit_outer_d = '0;
            emit_inner_d = '0;
          end else if (inner_end) begin
            emit_inner_d = '0;
            emit_outer_d = o + DIM_W'(1);
          end else begin
            emit_inner_d = i + DIM_W'(1);
            emit_outer_d = o;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
      frame_full_q <= 1'b0;
      emit_outer_q <= '0;
      emit_inner_q <= '0;
    end else begin
      load_count_q <= load_count_d;
      frame_full_q <= frame_full_d;
      emit_outer_q <= emit_outer_d;
      emit_inner_q <= emit_inner_d;
    end
  end

endmodule

>>> sv/rar_queue.sv
// Short operation queue between front end and back end.
// Holds store operations in order. Depends on rar_pkg.
module rar_queue import rar_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  rar_op_t op_i,
  input  logic    pop_i,
  output logic    valid_o,
  output rar_op_t op_o,
  output logic    full_o
);

  rar_op_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_q, rptr_q;
  logic [QPTR_W:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign op_o    = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

>>> sv/rar_back.sv
// Back end: pixel store and result register.
// Writes loads, reads drains and presents one result per drain. Depends on rar_pkg.
module rar_back import rar_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     op_valid_i,
  input  rar_op_t  op_i,
  output logic     res_valid_o,
  output rar_res_t res_o
);

  logic [PIX_W-1:0] store_mem [STORE_DEPTH];
  logic [PIX_W-1:0] rdata_q;
  rar_op_t          meta_q;
  logic             valid_q;

  always_ff @(posedge clk_i) begin
    if (op_valid_i && op_i.wr) begin
      store_mem[op_i.addr] <= op_i.pixel;
    end
    if (op_valid_i && op_i.rd) begin
      rdata_q <= store_mem[op_i.addr];
      meta_q  <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= op_valid_i && op_i.rd;
    end
  end

  assign res_valid_o        = valid_q;
  assign res_o.pixel_out    = meta_q.ready ? rdata_q : '0;
  assign res_o.last_pixel   = meta_q.last;
  assign res_o.ready_res    = meta_q.ready;
  assign res_o.new_origin_x = meta_q.nox;
  assign res_o.new_origin_y = meta_q.noy;

endmodule

>>> sv/right_angle_image_rotator.sv
// Top level of the right-angle image rotator.
// Instantiates rar_front, rar_queue and rar_back; depends on rar_pkg.
//
// Usage:
//   Item channel: drive item_i and raise start_i; the item is taken at a rising
//   edge where start_i is high and busy_o is low. A load item (command 0) stores
//   one source pixel in raster order; a drain item (command 1) yields one result.
//   Result channel: res_valid_o is high for exactly one cycle per drain with
//   res_o; the receiver must take it then.
//   Config: cfg_we_i, cfg_idx_i, cfg_wdata_i write one register per edge
//   (0 width, 1 height, 2 rotation mode, 3 origin x, 4 origin y); write only
//   while idle.
//   Throughput: one item per cycle. The front end maps one item per cycle and
//   the store takes one write or one read per cycle, so busy_o stays low.
//   Result path: an accepted drain passes the queue stage, then the registered
//   store read, before its result shows on res_o with res_valid_o.
//   Reset: counters clear, registers return to 64 x 64, mode none, origin 0;
//   the pixel store is not cleared and needs no clearing pass.
module right_angle_image_rotator import rar_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  rar_in_t              item_i,
  output logic                 res_valid_o,
  output rar_res_t             res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_wdata_i
);

  rar_op_t front_op, back_op;
  logic    accept, back_valid, q_full;

  assign accept = start_i && !q_full;
  assign busy_o = q_full;

  rar_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (item_i),
    .op_o        (front_op)
  );

  rar_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .op_i    (front_op),
    .pop_i   (1'b1),
    .valid_o (back_valid),
    .op_o    (back_op),
    .full_o  (q_full)
  );

  rar_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (back_valid),
    .op_i        (back_op),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

>>> sv/rar_checker.sv
// Port-level checks for the right-angle image rotator.
// Bound to right_angle_image_rotator; depends on rar_pkg.
module rar_checker import rar_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input rar_in_t              item_i,
  input logic                 res_valid_o,
  input rar_res_t             res_o,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [DIM_W-1:0]     cfg_wdata_i
);

  logic drain_acc;
  assign drain_acc = start_i && !busy_o && (item_i.command == CMD_DRAIN);

  a_res_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(drain_acc, 2))
    else $error("result without a drain two cycles earlier");

  a_drain_gives_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(drain_acc, 2) && $past(rst_ni, 2) && $past(rst_ni, 1)) |-> res_valid_o)
    else $error("drain lost");

  a_not_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.ready_res) |-> (res_o.pixel_out == '0 && !res_o.last_pixel))
    else $error("early drain must give zero pixel and no last flag");

  a_load_no_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && item_i.command == CMD_LOAD) |=> ##1 !res_valid_o ||
      $past(drain_acc, 2))
    else $error("load produced a result");

endmodule

bind right_angle_image_rotator rar_checker u_rar_checker (.*);
